// ===== sv/abrf_pkg.sv =====
`timescale 1ns / 1ps
package abrf_pkg;

  typedef enum logic [2:0] {
    OpReadReg   = 3'd0,
    OpWriteReg  = 3'd1,
    OpSwitch    = 3'd2,
    OpReadCpsr  = 3'd3,
    OpWriteCpsr = 3'd4,
    OpReadSpsr  = 3'd5,
    OpWriteSpsr = 3'd6,
    OpIrq       = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    BankNone = 3'd0,
    BankFiq  = 3'd1,
    BankIrq  = 3'd2,
    BankSvc  = 3'd3,
    BankAbt  = 3'd4,
    BankUnd  = 3'd5
  } bank_t;

  localparam logic [4:0] ModeFiq = 5'd17;
  localparam logic [4:0] ModeIrq = 5'd18;
  localparam logic [4:0] ModeSvc = 5'd19;
  localparam logic [4:0] ModeAbt = 5'd23;
  localparam logic [4:0] ModeUnd = 5'd27;

  localparam int NumLive  = 16;
  localparam int NumSlots = 42;
  localparam int NumBanks = 6;
  localparam int DataW    = 32;

  localparam int ThumbBit   = 5;
  localparam int IrqMaskBit = 7;

  localparam logic [DataW-1:0] CpsrReset  = 32'h0000_00D3;
  localparam logic [DataW-1:0] IrqOffset  = 32'h0000_0018;
  localparam logic [DataW-1:0] ArmPcAdj   = 32'd8;
  localparam logic [DataW-1:0] ThumbPcAdj = 32'd4;
  localparam logic [DataW-1:0] LrArmAdj   = 32'd4;

  // slot numbers within a bank: slot 0 is r8, slot 6 is r14
  localparam logic [2:0] SlotR13  = 3'd5;
  localparam logic [2:0] SlotLast = 3'd6;

  localparam logic [3:0] LiveLr = 4'd14;
  localparam logic [3:0] LivePc = 4'd15;
  localparam logic [3:0] FiqLimit  = 4'd8;
  localparam logic [3:0] BankLimit = 4'd13;

  function automatic bank_t bank_of(logic [4:0] m);
    bank_t b;
    unique case (m)
      ModeFiq: b = BankFiq;
      ModeIrq: b = BankIrq;
      ModeSvc: b = BankSvc;
      ModeAbt: b = BankAbt;
      ModeUnd: b = BankUnd;
      default: b = BankNone;
    endcase
    return b;
  endfunction

  // seven slots per bank: base = 8*b - b
  function automatic logic [5:0] slot_base(bank_t b);
    logic [5:0] w;
    w = {3'b000, b};
    return (w << 3) - w;
  endfunction

endpackage

// ===== sv/abrf_ram.sv =====
`timescale 1ns / 1ps
module abrf_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/arm_banked_register_file.sv =====
`timescale 1ns / 1ps
// Request taken at an edge with start high and busy low; out_valid strobes once per request.
// Writes, status ops, masked IRQ, same-bank switch end in the execute state; a read waits on
// the RAM; a switch swaps r13-r14 (r8-r14 when FIQ is on either side); an IRQ then reads PC,
// writes LR, writes PC. busy falls as the result shows, so a request holds the block to its end;
// one write port per RAM: one bank slot moves a cycle. The receiver cannot stall.
// Synchronous active-low reset: CPSR 0xD3, vector base 0, RAM valid bits cleared, no clear pass.
module arm_banked_register_file (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_reg_index,
  input  logic [4:0]  in_target_mode,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_irq_taken,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int LiveAw = $clog2(abrf_pkg::NumLive);
  localparam int SlotAw = $clog2(abrf_pkg::NumSlots);
  localparam int DW     = abrf_pkg::DataW;

  typedef enum logic [7:0] {
    StIdle     = 8'b0000_0001,
    StExec     = 8'b0000_0010,
    StRdWait   = 8'b0000_0100,
    StSwap     = 8'b0000_1000,
    StSwapLast = 8'b0001_0000,
    StIrqRd    = 8'b0010_0000,
    StIrqLr    = 8'b0100_0000,
    StIrqPc    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  abrf_pkg::op_t req_op_r;
  logic [3:0]    req_reg_r;
  logic [4:0]    req_tmode_r;
  logic [DW-1:0] req_wval_r;

  logic [DW-1:0] cpsr_r, cpsr_nxt;
  logic [DW-1:0] vb_r;
  logic [DW-1:0] spsr_r [abrf_pkg::NumBanks];

  logic [abrf_pkg::NumLive-1:0]  live_vld_r;
  logic [abrf_pkg::NumSlots-1:0] bank_vld_r;
  logic live_rvld_r, bank_rvld_r;

  abrf_pkg::bank_t from_r, from_nxt, to_r, to_nxt;
  logic [2:0] idx_r, idx_nxt, wr_idx_r, wr_idx_nxt;
  logic       pend_r, pend_nxt;
  logic       rd_bank_r, rd_bank_nxt;
  logic       thumb_r, thumb_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic          out_irq_r, out_irq_nxt;

  logic              spsr_we;
  abrf_pkg::bank_t   spsr_wsel;
  logic [DW-1:0]     spsr_wdata;

  logic              live_we, live_re;
  logic [LiveAw-1:0] live_waddr, live_raddr;
  logic [DW-1:0]     live_wdata, live_rdata, live_q;
  logic              bank_we, bank_re;
  logic [SlotAw-1:0] bank_waddr, bank_raddr;
  logic [DW-1:0]     bank_wdata, bank_rdata, bank_q;

  logic              use_bank;
  logic [3:0]        limit;
  logic [SlotAw-1:0] acc_addr;
  logic [4:0]        sw_mode;
  abrf_pkg::bank_t   sw_from, sw_to;
  logic              sw_full;

  abrf_ram #(.Width(DW), .Depth(abrf_pkg::NumLive)) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .re    (live_re),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  abrf_ram #(.Width(DW), .Depth(abrf_pkg::NumSlots)) u_bank_ram (
    .clk   (clk),
    .we    (bank_we),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .re    (bank_re),
    .raddr (bank_raddr),
    .rdata (bank_rdata)
  );

  // never-written entries read as their reset value of zero
  assign live_q = live_rvld_r ? live_rdata : '0;
  assign bank_q = bank_rvld_r ? bank_rdata : '0;

  assign limit = (req_tmode_r == abrf_pkg::ModeFiq) ? abrf_pkg::FiqLimit : abrf_pkg::BankLimit;
  assign use_bank = (cpsr_r[4:0] != req_tmode_r) && (req_reg_r >= limit) &&
                    (req_reg_r != abrf_pkg::LivePc);
  // r8..r14 map to slots 0..6, which is the low three bits of the index
  assign acc_addr = abrf_pkg::slot_base(abrf_pkg::bank_of(req_tmode_r)) +
                    {3'b000, req_reg_r[2:0]};

  assign sw_mode = (req_op_r == abrf_pkg::OpIrq) ? abrf_pkg::ModeIrq : req_tmode_r;
  assign sw_from = abrf_pkg::bank_of(cpsr_r[4:0]);
  assign sw_to   = abrf_pkg::bank_of(sw_mode);
  assign sw_full = (sw_from == abrf_pkg::BankFiq) || (sw_to == abrf_pkg::BankFiq);

  always_comb begin
    state_nxt     = state_r;
    cpsr_nxt      = cpsr_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    idx_nxt       = idx_r;
    wr_idx_nxt    = wr_idx_r;
    pend_nxt      = pend_r;
    rd_bank_nxt   = rd_bank_r;
    thumb_nxt     = thumb_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    out_irq_nxt   = 1'b0;
    spsr_we       = 1'b0;
    spsr_wsel     = abrf_pkg::bank_of(req_tmode_r);
    spsr_wdata    = req_wval_r;
    live_we       = 1'b0;
    live_waddr    = req_reg_r;
    live_wdata    = req_wval_r;
    live_re       = 1'b0;
    live_raddr    = req_reg_r;
    bank_we       = 1'b0;
    bank_waddr    = acc_addr;
    bank_wdata    = req_wval_r;
    bank_re       = 1'b0;
    bank_raddr    = acc_addr;

    unique case (state_r)
      StIdle: begin
        if (start) begin
          state_nxt = StExec;
        end
      end
      StExec: begin
        unique case (req_op_r)
          abrf_pkg::OpReadReg: begin
            bank_re     = use_bank;
            live_re     = !use_bank;
            rd_bank_nxt = use_bank;
            state_nxt   = StRdWait;
          end
          abrf_pkg::OpWriteReg: begin
            if (req_reg_r == abrf_pkg::LivePc) begin
              live_we    = 1'b1;
              live_wdata = req_wval_r + (cpsr_r[abrf_pkg::ThumbBit] ?
                                         abrf_pkg::ThumbPcAdj : abrf_pkg::ArmPcAdj);
            end else if (use_bank) begin
              bank_we = 1'b1;
            end else begin
              live_we = 1'b1;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = StIdle;
          end
          abrf_pkg::OpReadCpsr: begin
            out_data_nxt  = cpsr_r;
            out_valid_nxt = 1'b1;
            state_nxt     = StIdle;
          end
          abrf_pkg::OpWriteCpsr: begin
            cpsr_nxt      = req_wval_r;
            out_valid_nxt = 1'b1;
            state_nxt     = StIdle;
          end
          abrf_pkg::OpReadSpsr: begin
            out_data_nxt  = spsr_r[abrf_pkg::bank_of(req_tmode_r)];
            out_valid_nxt = 1'b1;
            state_nxt     = StIdle;
          end
          abrf_pkg::OpWriteSpsr: begin
            spsr_we       = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = StIdle;
          end
          abrf_pkg::OpSwitch, abrf_pkg::OpIrq: begin
            if (req_op_r == abrf_pkg::OpIrq && cpsr_r[abrf_pkg::IrqMaskBit]) begin
              // masked: drop the request with irq_taken low
              out_valid_nxt = 1'b1;
              state_nxt     = StIdle;
            end else begin
              cpsr_nxt[4:0] = sw_mode;
              if (req_op_r == abrf_pkg::OpIrq) begin
                spsr_we    = 1'b1;
                spsr_wsel  = abrf_pkg::BankIrq;
                spsr_wdata = cpsr_r;
                cpsr_nxt[abrf_pkg::IrqMaskBit] = 1'b1;
                cpsr_nxt[abrf_pkg::ThumbBit]   = 1'b0;
                thumb_nxt = cpsr_r[abrf_pkg::ThumbBit];
              end
              from_nxt = sw_from;
              to_nxt   = sw_to;
              idx_nxt  = sw_full ? 3'd0 : abrf_pkg::SlotR13;
              pend_nxt = 1'b0;
              if (sw_from != sw_to) begin
                state_nxt = StSwap;
              end else if (req_op_r == abrf_pkg::OpIrq) begin
                state_nxt = StIrqRd;
              end else begin
                out_valid_nxt = 1'b1;
                state_nxt     = StIdle;
              end
            end
          end
        endcase
      end
      StRdWait: begin
        out_data_nxt  = rd_bank_r ? bank_q : live_q;
        out_valid_nxt = 1'b1;
        state_nxt     = StIdle;
      end
      StSwap, StSwapLast: begin
        // read slot idx while writing back the slot read the cycle before
        if (pend_r) begin
          live_we    = 1'b1;
          live_waddr = {1'b1, wr_idx_r};
          live_wdata = bank_q;
          bank_we    = 1'b1;
          bank_waddr = abrf_pkg::slot_base(from_r) + {3'b000, wr_idx_r};
          bank_wdata = live_q;
        end
        if (state_r == StSwap) begin
          live_re    = 1'b1;
          live_raddr = {1'b1, idx_r};
          bank_re    = 1'b1;
          bank_raddr = abrf_pkg::slot_base(to_r) + {3'b000, idx_r};
          pend_nxt   = 1'b1;
          wr_idx_nxt = idx_r;
          if (idx_r == abrf_pkg::SlotLast) begin
            state_nxt = StSwapLast;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end else begin
          pend_nxt = 1'b0;
          if (req_op_r == abrf_pkg::OpIrq) begin
            state_nxt = StIrqRd;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = StIdle;
          end
        end
      end
      StIrqRd: begin
        live_re    = 1'b1;
        live_raddr = abrf_pkg::LivePc;
        state_nxt  = StIrqLr;
      end
      StIrqLr: begin
        live_we    = 1'b1;
        live_waddr = abrf_pkg::LiveLr;
        live_wdata = thumb_r ? live_q : live_q - abrf_pkg::LrArmAdj;
        state_nxt  = StIrqPc;
      end
      StIrqPc: begin
        live_we       = 1'b1;
        live_waddr    = abrf_pkg::LivePc;
        live_wdata    = vb_r + abrf_pkg::IrqOffset + abrf_pkg::ArmPcAdj;
        out_valid_nxt = 1'b1;
        out_irq_nxt   = 1'b1;
        state_nxt     = StIdle;
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      cpsr_r      <= abrf_pkg::CpsrReset;
      vb_r        <= '0;
      live_vld_r  <= '0;
      bank_vld_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < abrf_pkg::NumBanks; i++) begin
        spsr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cpsr_r      <= cpsr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        vb_r <= cfg_wdata;
      end
      if (spsr_we) begin
        spsr_r[spsr_wsel] <= spsr_wdata;
      end
      if (live_we) begin
        live_vld_r[live_waddr] <= 1'b1;
      end
      if (bank_we) begin
        bank_vld_r[bank_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == StIdle && start) begin
      req_op_r    <= abrf_pkg::op_t'(in_mode);
      req_reg_r   <= in_reg_index;
      req_tmode_r <= in_target_mode;
      req_wval_r  <= in_write_value;
    end
    if (live_re) begin
      live_rvld_r <= live_vld_r[live_raddr];
    end
    if (bank_re) begin
      bank_rvld_r <= bank_vld_r[bank_raddr];
    end
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    idx_r      <= idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    rd_bank_r  <= rd_bank_nxt;
    thumb_r    <= thumb_nxt;
    out_data_r <= out_data_nxt;
    out_irq_r  <= out_irq_nxt;
  end

  assign busy          = (state_r != StIdle);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq_taken = out_irq_r;

endmodule

// ===== dv/tb_arm_banked_register_file.sv =====
`timescale 1ns / 1ps

typedef struct packed {
  logic [31:0] read_data;
  logic        irq_taken;
} access_result_t;

class regfile_scoreboard;
  logic [31:0] live_regs [abrf_pkg::NumLive];
  logic [31:0] bank_slots [abrf_pkg::NumSlots];
  logic [31:0] saved_psr [abrf_pkg::NumBanks];
  logic [31:0] cpsr;
  logic [31:0] vector_base;
  access_result_t expected_results [$];
  int fail_count;

  function new();
    foreach (live_regs[i]) live_regs[i] = '0;
    foreach (bank_slots[i]) bank_slots[i] = '0;
    foreach (saved_psr[i]) saved_psr[i] = '0;
    cpsr = abrf_pkg::CpsrReset;
    vector_base = '0;
    live_regs[abrf_pkg::LivePc] = vector_base;
    fail_count = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void set_vector_base(logic [31:0] value);
    vector_base = value;
  endfunction

  // any mode code outside the privileged set shares the user/system bank
  function abrf_pkg::bank_t bank_for(logic [4:0] m);
    case (m)
      abrf_pkg::ModeFiq: return abrf_pkg::BankFiq;
      abrf_pkg::ModeIrq: return abrf_pkg::BankIrq;
      abrf_pkg::ModeSvc: return abrf_pkg::BankSvc;
      abrf_pkg::ModeAbt: return abrf_pkg::BankAbt;
      abrf_pkg::ModeUnd: return abrf_pkg::BankUnd;
      default: return abrf_pkg::BankNone;
    endcase
  endfunction

  function int slot_of(abrf_pkg::bank_t b, int reg_num);
    return int'(b) * 7 + reg_num - 8;
  endfunction

  function bit banked(logic [3:0] r, logic [4:0] m);
    logic [3:0] first_banked;
    first_banked = (m == abrf_pkg::ModeFiq) ? abrf_pkg::FiqLimit : abrf_pkg::BankLimit;
    return cpsr[4:0] != m && r >= first_banked && r != abrf_pkg::LivePc;
  endfunction

  function void swap_banks(logic [4:0] next_mode);
    abrf_pkg::bank_t src_bank;
    abrf_pkg::bank_t dst_bank;
    src_bank = bank_for(cpsr[4:0]);
    dst_bank = bank_for(next_mode);
    cpsr[4:0] = next_mode;
    if (src_bank == dst_bank) return;
    if (src_bank == abrf_pkg::BankFiq || dst_bank == abrf_pkg::BankFiq) begin
      for (int i = 8; i < 15; i++) bank_slots[slot_of(src_bank, i)] = live_regs[i];
      for (int i = 8; i < 15; i++) live_regs[i] = bank_slots[slot_of(dst_bank, i)];
    end else begin
      for (int i = 13; i < 15; i++) bank_slots[slot_of(src_bank, i)] = live_regs[i];
      for (int i = 13; i < 15; i++) live_regs[i] = bank_slots[slot_of(dst_bank, i)];
    end
  endfunction

  function void note_request(abrf_pkg::op_t op, logic [3:0] r, logic [4:0] m,
                             logic [31:0] v);
    access_result_t res;
    res = '0;
    case (op)
      abrf_pkg::OpReadReg: begin
        if (banked(r, m)) res.read_data = bank_slots[slot_of(bank_for(m), int'(r))];
        else res.read_data = live_regs[r];
      end
      abrf_pkg::OpWriteReg: begin
        if (r == abrf_pkg::LivePc)
          live_regs[abrf_pkg::LivePc] = v + (cpsr[abrf_pkg::ThumbBit] ?
                                             abrf_pkg::ThumbPcAdj : abrf_pkg::ArmPcAdj);
        else if (banked(r, m)) bank_slots[slot_of(bank_for(m), int'(r))] = v;
        else live_regs[r] = v;
      end
      abrf_pkg::OpSwitch: swap_banks(m);
      abrf_pkg::OpReadCpsr: res.read_data = cpsr;
      abrf_pkg::OpWriteCpsr: cpsr = v;
      abrf_pkg::OpReadSpsr: res.read_data = saved_psr[int'(bank_for(m))];
      abrf_pkg::OpWriteSpsr: saved_psr[int'(bank_for(m))] = v;
      abrf_pkg::OpIrq: begin
        if (!cpsr[abrf_pkg::IrqMaskBit]) begin
          saved_psr[int'(abrf_pkg::BankIrq)] = cpsr;
          swap_banks(abrf_pkg::ModeIrq);
          cpsr[abrf_pkg::IrqMaskBit] = 1'b1;
          if (cpsr[abrf_pkg::ThumbBit]) begin
            cpsr[abrf_pkg::ThumbBit] = 1'b0;
            live_regs[abrf_pkg::LiveLr] = live_regs[abrf_pkg::LivePc];
          end else begin
            live_regs[abrf_pkg::LiveLr] = live_regs[abrf_pkg::LivePc] - abrf_pkg::LrArmAdj;
          end
          live_regs[abrf_pkg::LivePc] = vector_base + abrf_pkg::IrqOffset + abrf_pkg::ArmPcAdj;
          res.irq_taken = 1'b1;
        end
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH %s", what);
    fail_count++;
  endtask

  task check_result(logic [31:0] rd, logic taken);
    access_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with no request pending: data %h irq %b", rd, taken));
      return;
    end
    want = expected_results.pop_front();
    if (rd !== want.read_data)
      report_mismatch($sformatf("read_data %h, want %h", rd, want.read_data));
    if (taken !== want.irq_taken)
      report_mismatch($sformatf("irq_taken %b, want %b", taken, want.irq_taken));
  endtask
endclass

module tb_arm_banked_register_file;
  localparam int CycleLimit    = 500_000;
  localparam int ItemsPerPhase = 345;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_mode;
  logic [3:0]  in_reg_index;
  logic [4:0]  in_target_mode;
  logic [31:0] in_write_value;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic        out_irq_taken;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  regfile_scoreboard sb;
  int cycle_count = 0;
  int sent_count = 0;
  int idle_pct = 30;

  arm_banked_register_file i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_reg_index   (in_reg_index),
    .in_target_mode (in_target_mode),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_irq_taken  (out_irq_taken),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("arm_banked_register_file verification failed");
      $finish;
    end
  end

  // retire the result first: the next request may be taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_read_data, out_irq_taken);
      if (start && !busy)
        sb.note_request(abrf_pkg::op_t'(in_mode), in_reg_index, in_target_mode,
                        in_write_value);
    end
  end

  function automatic logic [4:0] pick_mode();
    case ($urandom_range(0, 9))
      0: return 5'd16;
      1: return abrf_pkg::ModeFiq;
      2: return abrf_pkg::ModeIrq;
      3: return abrf_pkg::ModeSvc;
      4: return abrf_pkg::ModeAbt;
      5: return abrf_pkg::ModeUnd;
      6: return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic abrf_pkg::op_t pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return abrf_pkg::OpReadReg;
    if (roll < 50) return abrf_pkg::OpWriteReg;
    if (roll < 65) return abrf_pkg::OpSwitch;
    if (roll < 70) return abrf_pkg::OpReadCpsr;
    if (roll < 78) return abrf_pkg::OpWriteCpsr;
    if (roll < 85) return abrf_pkg::OpReadSpsr;
    if (roll < 92) return abrf_pkg::OpWriteSpsr;
    return abrf_pkg::OpIrq;
  endfunction

  function automatic int pick_gap();
    int roll;
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // hold the request until an edge sees busy low, then sometimes go idle for a random gap
  task automatic issue(abrf_pkg::op_t op, logic [3:0] r, logic [4:0] m, logic [31:0] v);
    int gap;
    start          <= 1'b1;
    in_mode        <= op;
    in_reg_index   <= r;
    in_target_mode <= m;
    in_write_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_vector_base(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_vector_base(value);
  endtask

  // unmask, set the PC, take the IRQ and read back what it left behind
  task automatic irq_sequence();
    logic [31:0] psr;
    psr = $urandom;
    psr[abrf_pkg::IrqMaskBit] = 1'b0;
    psr[abrf_pkg::ThumbBit] = 1'($urandom_range(0, 1));
    psr[4:0] = pick_mode();
    issue(abrf_pkg::OpWriteCpsr, 4'($urandom_range(0, 15)), pick_mode(), psr);
    issue(abrf_pkg::OpWriteReg, abrf_pkg::LivePc, pick_mode(), pick_word());
    repeat ($urandom_range(0, 2))
      issue(pick_op(), 4'($urandom_range(0, 15)), pick_mode(), pick_word());
    issue(abrf_pkg::OpIrq, 4'($urandom_range(0, 15)), pick_mode(), pick_word());
    issue(abrf_pkg::OpReadReg, abrf_pkg::LiveLr, abrf_pkg::ModeIrq, pick_word());
    issue(abrf_pkg::OpReadSpsr, 4'($urandom_range(0, 15)), abrf_pkg::ModeIrq, pick_word());
    issue(abrf_pkg::OpReadCpsr, 4'($urandom_range(0, 15)), pick_mode(), pick_word());
    issue(abrf_pkg::OpReadReg, abrf_pkg::LivePc, pick_mode(), pick_word());
  endtask

  task automatic random_phase(logic [31:0] vbase, int idle);
    int stop_at;
    int roll;
    drain();
    write_vector_base(vbase);
    idle_pct = idle;
    stop_at = sent_count + ItemsPerPhase;
    while (sent_count < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) irq_sequence();
      else if (roll < 13) drain();
      else issue(pick_op(), 4'($urandom_range(0, 15)), pick_mode(), pick_word());
    end
  endtask

  initial begin
    sb = new();
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_mode        <= abrf_pkg::OpReadReg;
    in_reg_index   <= '0;
    in_target_mode <= '0;
    in_write_value <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state, masked IRQ, PC offset wrap
    issue(abrf_pkg::OpReadCpsr, 4'd0, abrf_pkg::ModeSvc, 32'h0);
    issue(abrf_pkg::OpReadReg, abrf_pkg::LivePc, abrf_pkg::ModeSvc, 32'h0);
    issue(abrf_pkg::OpIrq, 4'd0, abrf_pkg::ModeSvc, 32'h0);
    issue(abrf_pkg::OpWriteReg, abrf_pkg::LivePc, abrf_pkg::ModeSvc, 32'hFFFF_FFFC);
    // live versus banked access from svc
    issue(abrf_pkg::OpWriteReg, 4'd13, abrf_pkg::ModeSvc, 32'hFFFF_FFFF);
    issue(abrf_pkg::OpWriteReg, 4'd8, abrf_pkg::ModeFiq, 32'hA5A5_A5A5);
    issue(abrf_pkg::OpWriteReg, 4'd13, 5'd16, 32'h1234_5678);
    issue(abrf_pkg::OpWriteReg, 4'd14, 5'd0, 32'h8765_4321);
    issue(abrf_pkg::OpReadReg, 4'd8, abrf_pkg::ModeFiq, 32'h0);
    // fiq swaps r8 to r14
    issue(abrf_pkg::OpSwitch, 4'd0, abrf_pkg::ModeFiq, 32'h0);
    issue(abrf_pkg::OpReadReg, 4'd8, abrf_pkg::ModeFiq, 32'h0);
    issue(abrf_pkg::OpReadReg, 4'd13, abrf_pkg::ModeSvc, 32'h0);
    issue(abrf_pkg::OpSwitch, 4'd0, 5'd16, 32'h0);
    issue(abrf_pkg::OpWriteSpsr, 4'd0, abrf_pkg::ModeIrq, 32'hDEAD_BEEF);
    issue(abrf_pkg::OpReadSpsr, 4'd0, abrf_pkg::ModeIrq, 32'h0);
    // thumb state, IRQ unmasked: no swap on CPSR write
    issue(abrf_pkg::OpWriteCpsr, 4'd0, abrf_pkg::ModeSvc, 32'h0000_0030);
    issue(abrf_pkg::OpWriteReg, abrf_pkg::LivePc, 5'd16, 32'h0000_0100);
    issue(abrf_pkg::OpIrq, 4'd0, 5'd16, 32'h0);
    issue(abrf_pkg::OpReadReg, abrf_pkg::LiveLr, abrf_pkg::ModeIrq, 32'h0);
    issue(abrf_pkg::OpReadCpsr, 4'd0, abrf_pkg::ModeIrq, 32'h0);
    issue(abrf_pkg::OpReadSpsr, 4'd0, abrf_pkg::ModeIrq, 32'h0);
    // ARM state IRQ from system mode
    issue(abrf_pkg::OpWriteCpsr, 4'd0, abrf_pkg::ModeIrq, 32'h0000_001F);
    issue(abrf_pkg::OpIrq, 4'd0, 5'd31, 32'h0);
    issue(abrf_pkg::OpReadReg, abrf_pkg::LiveLr, abrf_pkg::ModeIrq, 32'h0);
    issue(abrf_pkg::OpSwitch, 4'd0, 5'd31, 32'h0);

    random_phase(32'hFFFF_FFFF, 30);
    random_phase(32'h0000_0000, 0);
    random_phase($urandom, 50);
    random_phase(32'hFFFF_FFE0, 30);
    drain();
    repeat (16) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("arm_banked_register_file verification clean");
    end else begin
      $display("arm_banked_register_file verification failed");
    end
    $finish;
  end
endmodule
